### src/ttc_pkg.sv
package ttc_pkg;

  // Character codes used by the scanner
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CMT_W     = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_B = 2'd1;
  localparam logic [CMT_W-1:0]     CMT_OFF       = 9'd256;

  // One result word
  typedef struct packed {
    logic [7:0] token_byte;
    logic       has_byte;
    logic       token_first;
    logic       token_last;
    logic       quoted;
    logic       unterminated;
    logic       run_last;
  } result_t;

  // Everything one input word produces: one or two result words
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_NL) || (b == CH_TAB) || (b == CH_CR) || (b == CH_SPACE);
  endfunction

  function automatic logic is_end(input logic [7:0] b);
    return is_space(b) || (b == CH_DQUOTE) || (b == CH_SEMI) || (b == CH_EQUALS) ||
           (b == CH_COMMA);
  endfunction

  function automatic logic is_single(input logic [7:0] b);
    return (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_LBRACE) ||
           (b == CH_RBRACE) || (b == CH_SEMI) || (b == CH_EQUALS);
  endfunction

endpackage

### src/ttc_scan.sv
module ttc_scan
  import ttc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 mode,
  input  logic [7:0]           text_byte,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CMT_W-1:0]     cfg_data,
  input  logic                 q_full,
  output logic                 q_wr,
  output entry_t               q_din
);

  typedef enum logic [1:0] {ST_IDLE, ST_PLAIN, ST_DQ, ST_SQ} scan_t;

  scan_t            scan, scan_next;
  logic             in_cmt, in_cmt_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic             held_is_first, held_is_first_next;
  logic [CMT_W-1:0] comment_char_a, comment_char_b;

  // Start-of-token decode for a byte seen between tokens
  scan_t            sfi_scan;
  logic             sfi_res;
  logic             sfi_hold;
  logic             sfi_clear;

  result_t          r0, r1;
  logic [1:0]       n;
  logic             accept;
  logic             is_cmt_byte;

  function automatic result_t mk_res(input logic [7:0] b, input logic has,
                                     input logic first, input logic last,
                                     input logic q, input logic unterm);
    result_t r;
    r.token_byte   = has ? b : 8'd0;
    r.has_byte     = has;
    r.token_first  = first;
    r.token_last   = last;
    r.quoted       = q;
    r.unterminated = unterm;
    r.run_last     = 1'b0;
    return r;
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;
  assign is_cmt_byte = ({1'b0, text_byte} == comment_char_a) ||
                       ({1'b0, text_byte} == comment_char_b);

  // Classify a byte arriving between tokens
  always_comb begin
    sfi_scan  = ST_IDLE;
    sfi_res   = 1'b0;
    sfi_hold  = 1'b0;
    sfi_clear = 1'b0;
    if (is_space(text_byte)) begin
      sfi_scan = ST_IDLE;
    end else if (is_single(text_byte)) begin
      sfi_res = 1'b1;
    end else if (text_byte == CH_DQUOTE) begin
      sfi_scan  = ST_DQ;
      sfi_clear = 1'b1;
    end else if (text_byte == CH_SQUOTE) begin
      sfi_scan  = ST_SQ;
      sfi_clear = 1'b1;
    end else begin
      sfi_scan = ST_PLAIN;
      sfi_hold = 1'b1;
    end
  end

  // Scanner step: next state and up to two result words
  always_comb begin
    scan_next          = scan;
    in_cmt_next        = in_cmt;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    held_is_first_next = held_is_first;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (mode) begin
      unique case (scan)
        ST_PLAIN: begin
          if (held_valid) begin
            r0 = mk_res(held_byte, 1'b1, held_is_first, 1'b1, 1'b0, 1'b0);
            n  = 2'd1;
          end
        end
        ST_DQ, ST_SQ: begin
          if (held_valid) begin
            r0 = mk_res(held_byte, 1'b1, held_is_first, 1'b0, 1'b1, 1'b0);
            r1 = mk_res(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
            n  = 2'd2;
          end else begin
            r0 = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
            n  = 2'd1;
          end
        end
        ST_IDLE: begin
          n = 2'd0;
        end
      endcase
      scan_next          = ST_IDLE;
      in_cmt_next        = 1'b0;
      held_valid_next    = 1'b0;
      held_is_first_next = 1'b0;
    end else if (in_cmt) begin
      if (text_byte == CH_NL) in_cmt_next = 1'b0;
    end else if (is_cmt_byte) begin
      if (text_byte != CH_NL) in_cmt_next = 1'b1;
    end else begin
      unique case (scan)
        ST_IDLE: begin
          scan_next = sfi_scan;
          if (sfi_res) begin
            r0 = mk_res(text_byte, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
            n  = 2'd1;
          end
          if (sfi_clear) begin
            held_valid_next    = 1'b0;
            held_is_first_next = 1'b0;
          end
          if (sfi_hold) begin
            held_byte_next     = text_byte;
            held_valid_next    = 1'b1;
            held_is_first_next = 1'b1;
          end
        end
        ST_PLAIN: begin
          if (is_end(text_byte)) begin
            // Token ends; the ending byte is handled as between tokens
            if (held_valid) begin
              r0 = mk_res(held_byte, 1'b1, held_is_first, 1'b1, 1'b0, 1'b0);
              if (sfi_res) begin
                r1 = mk_res(text_byte, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
                n  = 2'd2;
              end else begin
                n  = 2'd1;
              end
            end else if (sfi_res) begin
              r0 = mk_res(text_byte, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
              n  = 2'd1;
            end
            scan_next       = sfi_scan;
            held_valid_next = 1'b0;
            if (sfi_clear) held_is_first_next = 1'b0;
            if (sfi_hold) begin
              held_byte_next     = text_byte;
              held_valid_next    = 1'b1;
              held_is_first_next = 1'b1;
            end
          end else begin
            if (held_valid) begin
              r0 = mk_res(held_byte, 1'b1, held_is_first, 1'b0, 1'b0, 1'b0);
              n  = 2'd1;
            end
            held_is_first_next = !held_valid;
            held_byte_next     = text_byte;
            held_valid_next    = 1'b1;
          end
        end
        ST_DQ, ST_SQ: begin
          if (text_byte == ((scan == ST_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
            if (held_valid) begin
              r0 = mk_res(held_byte, 1'b1, held_is_first, 1'b1, 1'b1, 1'b0);
            end else begin
              r0 = mk_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
            end
            n                  = 2'd1;
            held_valid_next    = 1'b0;
            held_is_first_next = 1'b0;
            scan_next          = ST_IDLE;
          end else begin
            if (held_valid) begin
              r0 = mk_res(held_byte, 1'b1, held_is_first, 1'b0, 1'b1, 1'b0);
              n  = 2'd1;
            end
            held_is_first_next = !held_valid;
            held_byte_next     = text_byte;
            held_valid_next    = 1'b1;
          end
        end
      endcase
    end
    // Mark the last word of this input
    if (n == 2'd2) r1.run_last = 1'b1;
    else r0.run_last = 1'b1;
  end

  assign q_wr      = accept && (n != 2'd0);
  assign q_din.two = (n == 2'd2);
  assign q_din.r0  = r0;
  assign q_din.r1  = r1;

  // State and comment registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan           <= ST_IDLE;
      in_cmt         <= 1'b0;
      held_byte      <= 8'd0;
      held_valid     <= 1'b0;
      held_is_first  <= 1'b0;
      comment_char_a <= CMT_OFF;
      comment_char_b <= CMT_OFF;
    end else begin
      if (accept) begin
        scan          <= scan_next;
        in_cmt        <= in_cmt_next;
        held_byte     <= held_byte_next;
        held_valid    <= held_valid_next;
        held_is_first <= held_is_first_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COMMENT_A: comment_char_a <= cfg_data;
          CFG_COMMENT_B: comment_char_b <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

### src/ttc_queue.sv
module ttc_queue
  import ttc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t din,
  output logic   full,
  input  logic   rd,
  output entry_t dout,
  output logic   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_MAX);
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= din;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("queue count out of range");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (wr && !rd) |=> (count == $past(count) + 1'b1))
    else $error("queue count failed to rise");

endmodule

### src/ttc_emit.sv
module ttc_emit
  import ttc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     q_entry,
  input  logic       q_empty,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output result_t    res
);

  entry_t cur;
  logic   cur_valid;
  logic   sel;
  logic   take;
  logic   done;
  logic   load;

  assign res   = sel ? cur.r1 : cur.r0;
  assign empty = !cur_valid;
  assign take  = pop && cur_valid;
  assign done  = take && (sel || !cur.two);
  assign load  = !cur_valid || done;
  assign q_rd  = load && !q_empty;

  // Output register: steps through one or two words per entry
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (take && !sel && cur.two) begin
      sel <= 1'b1;
    end else if (load) begin
      cur_valid <= !q_empty;
      sel       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_entry;
  end

  a_sel_needs_two: assert property (@(posedge clk) disable iff (rst)
      sel |-> (cur_valid && cur.two))
    else $error("second word selected on a single-word entry");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
      (cur_valid && !pop) |=> (cur_valid && $stable(sel)))
    else $error("result word lost while stalled");
  a_first_word_first: assert property (@(posedge clk) disable iff (rst)
      (take && !sel && cur.two) |=> sel)
    else $error("second word skipped");

endmodule

### src/text_tokenizer_with_comment_strip.sv
// Byte-serial text tokenizer with comment stripping and quoted strings.
//
// Input channel (push/full): one word is a text byte (mode 0) or an end of
// text marker (mode 1). A word is taken at each edge with push high and full
// low; full rises only when the internal word queue is full.
// Result channel (empty/pop): token bytes with first/last marks, quoted and
// unterminated flags and run_last on the final word of each input word. The
// front scanner writes at most one queue entry per input word (one or two
// results); the output register steps through it, one result per cycle while pop is high.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high;
// index 0 and 1 set the two comment bytes, other indexes are ignored. Write
// only while the block is idle.
// Throughput: one input word per cycle while pop keeps up; a word that makes
// two results occupies the output register until both are popped. An accepted
// word passes through the queue and then the output register to the ports.
// A stalled receiver fills the queue (QUEUE_DEPTH entries) and then full rises.
// Reset: scanner idle, nothing held, queue empty, comment bytes disabled (256).
module text_tokenizer_with_comment_strip
  import ttc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 mode,
  input  logic [7:0]           text_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           token_byte,
  output logic                 has_byte,
  output logic                 token_first,
  output logic                 token_last,
  output logic                 quoted,
  output logic                 unterminated,
  output logic                 run_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CMT_W-1:0]     cfg_data
);

  entry_t  q_din, q_dout;
  logic    q_wr, q_rd, q_full, q_empty;
  result_t res;

  assign cfg_ready = 1'b1;

  ttc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .text_byte (text_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_din     (q_din)
  );

  ttc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .din   (q_din),
    .full  (q_full),
    .rd    (q_rd),
    .dout  (q_dout),
    .empty (q_empty)
  );

  ttc_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .q_entry (q_dout),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign token_byte   = res.token_byte;
  assign has_byte     = res.has_byte;
  assign token_first  = res.token_first;
  assign token_last   = res.token_last;
  assign quoted       = res.quoted;
  assign unterminated = res.unterminated;
  assign run_last     = res.run_last;

endmodule
